// ===== src/ges_pkg.sv =====
// ----------------------------------------------------------------------------
// ges_pkg
// Shared beat types and fixed-point helpers for the linear system solver.
// ----------------------------------------------------------------------------
package ges_pkg;

  localparam int ROW_W = 4;
  localparam int COL_W = 5;
  localparam int VAL_W = 32;
  localparam int ORD_W = 5;
  localparam int IDX_W = 4;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    solve_req;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] result;
    logic                    singular;
    logic                    last;
  } out_beat_t;

  function automatic logic signed [VAL_W-1:0] sat64(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/ges_div.sv =====
// ----------------------------------------------------------------------------
// ges_div
// Restoring fixed-point divider, one quotient bit per cycle, quotient
// truncated toward zero and saturated; a zero divisor returns zero and flags.
// ----------------------------------------------------------------------------
module ges_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [ges_pkg::VAL_W-1:0] num,
  input  logic signed [ges_pkg::VAL_W-1:0] den,
  output logic                           done,
  output logic signed [ges_pkg::VAL_W-1:0] quo,
  output logic                           dz
);

  localparam int NB = ges_pkg::VAL_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NB + 1);

  logic             busy_r, busy_nxt;
  logic             fin_r, fin_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      dv_r, dv_nxt;
  logic [NB-1:0]    qm_r, qm_nxt;
  logic             neg_r, neg_nxt;
  logic             dz_r, dz_nxt;
  logic [32:0]      trial;
  logic [32:0]      diff;
  logic [31:0]      na_mag;
  logic [31:0]      nd_mag;

  assign na_mag = num[31] ? 32'(-{1'b1, num}) : num;
  assign nd_mag = den[31] ? 32'(-{1'b1, den}) : den;
  assign trial  = {rem_r, qm_r[NB-1]};
  assign diff   = trial - {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    qm_nxt   = qm_r;
    neg_nxt  = neg_r;
    dz_nxt   = dz_r;
    if (start) begin
      dz_nxt  = (den == '0);
      neg_nxt = num[31] ^ den[31];
      dv_nxt  = nd_mag;
      rem_nxt = '0;
      qm_nxt  = {na_mag, {FRAC_BITS{1'b0}}};
      cnt_nxt = CNT_W'(NB);
      if (den == '0) begin
        qm_nxt  = '0;
        fin_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        qm_nxt  = {qm_r[NB-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        qm_nxt  = {qm_r[NB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    qm_r  <= qm_nxt;
    neg_r <= neg_nxt;
    dz_r  <= dz_nxt;
  end

  always_comb begin
    if (!neg_r) begin
      if (qm_r > NB'(32'h7FFF_FFFF)) begin
        quo = 32'sh7FFF_FFFF;
      end else begin
        quo = qm_r[31:0];
      end
    end else begin
      if (qm_r > NB'(32'h8000_0000)) begin
        quo = 32'sh8000_0000;
      end else begin
        quo = 32'(-qm_r[31:0]);
      end
    end
  end

  assign done = fin_r;
  assign dz   = dz_r;

endmodule

// ===== src/ges_core.sv =====
// ----------------------------------------------------------------------------
// ges_core
// Matrix store, working copy and solution store with the elimination and
// back-substitution sequencer; elimination steps read, compute and write back.
// ----------------------------------------------------------------------------
module ges_core #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16,
  parameter int CW        = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ges_pkg::in_beat_t  in_data,
  input  logic [CW-1:0]      m_act,
  output logic               out_valid,
  input  logic               out_stall,
  output ges_pkg::out_beat_t out_data
);

  localparam int NCOLS = MAX_ORDER + 1;
  localparam int NW    = MAX_ORDER * NCOLS;
  localparam int AW    = $clog2(NW);
  localparam int SW    = $clog2(MAX_ORDER);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_COPY    = 5'd1;
  localparam logic [4:0] S_CPEND   = 5'd2;
  localparam logic [4:0] S_PIV_RD  = 5'd3;
  localparam logic [4:0] S_PIV_CMP = 5'd4;
  localparam logic [4:0] S_SW_RD   = 5'd5;
  localparam logic [4:0] S_SW_WA   = 5'd6;
  localparam logic [4:0] S_SW_WB   = 5'd7;
  localparam logic [4:0] S_EL_RD   = 5'd8;
  localparam logic [4:0] S_EL_DIV  = 5'd9;
  localparam logic [4:0] S_EL_WT   = 5'd10;
  localparam logic [4:0] S_EL_RRD  = 5'd11;
  localparam logic [4:0] S_EL_MUL  = 5'd12;
  localparam logic [4:0] S_EL_SHF  = 5'd13;
  localparam logic [4:0] S_EL_WR   = 5'd14;
  localparam logic [4:0] S_BS_INIT = 5'd15;
  localparam logic [4:0] S_BS_XRD  = 5'd16;
  localparam logic [4:0] S_BS_XLD  = 5'd17;
  localparam logic [4:0] S_BS_RD   = 5'd18;
  localparam logic [4:0] S_BS_MUL  = 5'd19;
  localparam logic [4:0] S_BS_SHF  = 5'd20;
  localparam logic [4:0] S_BS_SUB  = 5'd21;
  localparam logic [4:0] S_BS_DRD  = 5'd22;
  localparam logic [4:0] S_BS_DIV  = 5'd23;
  localparam logic [4:0] S_BS_WT   = 5'd24;
  localparam logic [4:0] S_OUT_RD  = 5'd25;
  localparam logic [4:0] S_OUT_LD  = 5'd26;
  localparam logic [4:0] S_OUT_WT  = 5'd27;

  logic signed [31:0] aug_mem [NW];
  logic signed [31:0] wrk_mem [NW];
  logic signed [31:0] sol_mem [MAX_ORDER];

  logic [4:0]         state_r, state_nxt;
  logic [CW-1:0]      m_r, m_nxt;
  logic [CW-1:0]      i_r, i_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [CW-1:0]      j_r, j_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic               sing_r, sing_nxt;
  logic               cp_we_r;
  logic [AW-1:0]      cp_wa_r;
  logic signed [31:0] t_r, t_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [31:0] mp_r, mp_nxt;
  logic signed [63:0] p_r, p_nxt;
  logic               ov_r, ov_nxt;
  ges_pkg::out_beat_t od_r, od_nxt;

  logic [AW-1:0]      ra, rb, wa, aug_ra;
  logic signed [31:0] qa_r, qb_r, aug_q_r, wd;
  logic               we;
  logic [SW-1:0]      sol_ra, sol_wa;
  logic signed [31:0] sol_q_r, sol_wd;
  logic               sol_we;
  logic               in_acc, in_ok;
  logic               dv_start, dv_done, dv_dz;
  logic signed [31:0] dv_num, dv_den, dv_quo;
  logic [32:0]        mag_a, mag_b;
  logic signed [63:0] p_shf;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r * NCOLS + c);
  endfunction

  ges_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo),
    .dz    (dv_dz)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_ok    = (32'(in_data.row) < MAX_ORDER) && (32'(in_data.col) <= MAX_ORDER);
  assign mag_a    = qa_r[31] ? 33'(-{qa_r[31], qa_r}) : {1'b0, qa_r};
  assign mag_b    = qb_r[31] ? 33'(-{qb_r[31], qb_r}) : {1'b0, qb_r};
  assign p_shf    = p_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (in_acc && in_ok) begin
      aug_mem[addr(CW'(in_data.row), CW'(in_data.col))] <= in_data.value;
    end
    aug_q_r <= aug_mem[aug_ra];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      wrk_mem[wa] <= wd;
    end
    qa_r <= wrk_mem[ra];
    qb_r <= wrk_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (sol_we) begin
      sol_mem[sol_wa] <= sol_wd;
    end
    sol_q_r <= sol_mem[sol_ra];
  end

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    sing_nxt  = sing_r;
    t_nxt     = t_r;
    x_nxt     = x_r;
    mp_nxt    = mp_r;
    p_nxt     = p_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ra        = '0;
    rb        = '0;
    aug_ra    = cnt_r;
    we        = cp_we_r;
    wa        = cp_wa_r;
    wd        = aug_q_r;
    sol_ra    = SW'(j_r);
    sol_we    = 1'b0;
    sol_wa    = SW'(i_r);
    sol_wd    = dv_quo;
    dv_start  = 1'b0;
    dv_num    = qa_r;
    dv_den    = qb_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.solve_req) begin
          m_nxt     = m_act;
          cnt_nxt   = '0;
          sing_nxt  = 1'b0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        if (cnt_r == AW'(NW - 1)) begin
          state_nxt = S_CPEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CPEND: begin
        i_nxt = '0;
        k_nxt = CW'(1);
        state_nxt = (m_r == CW'(1)) ? S_BS_INIT : S_PIV_RD;
      end
      S_PIV_RD: begin
        ra = addr(i_r, i_r);
        rb = addr(k_r, i_r);
        state_nxt = S_PIV_CMP;
      end
      S_PIV_CMP: begin
        if (mag_a < mag_b) begin
          j_nxt     = '0;
          state_nxt = S_SW_RD;
        end else if (k_r == m_r - 1'b1) begin
          k_nxt     = i_r + 1'b1;
          state_nxt = S_EL_RD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_PIV_RD;
        end
      end
      S_SW_RD: begin
        ra = addr(i_r, j_r);
        rb = addr(k_r, j_r);
        state_nxt = S_SW_WA;
      end
      S_SW_WA: begin
        we        = 1'b1;
        wa        = addr(i_r, j_r);
        wd        = qb_r;
        t_nxt     = qa_r;
        state_nxt = S_SW_WB;
      end
      S_SW_WB: begin
        we = 1'b1;
        wa = addr(k_r, j_r);
        wd = t_r;
        if (j_r == CW'(NCOLS - 1)) begin
          if (k_r == m_r - 1'b1) begin
            k_nxt     = i_r + 1'b1;
            state_nxt = S_EL_RD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_PIV_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SW_RD;
        end
      end
      S_EL_RD: begin
        ra = addr(k_r, i_r);
        rb = addr(i_r, i_r);
        state_nxt = S_EL_DIV;
      end
      S_EL_DIV: begin
        dv_start  = 1'b1;
        state_nxt = S_EL_WT;
      end
      S_EL_WT: begin
        if (dv_done) begin
          t_nxt     = dv_quo;
          sing_nxt  = sing_r | dv_dz;
          j_nxt     = i_r;
          state_nxt = S_EL_RRD;
        end
      end
      S_EL_RRD: begin
        ra = addr(k_r, j_r);
        rb = addr(i_r, j_r);
        state_nxt = S_EL_MUL;
      end
      S_EL_MUL: begin
        p_nxt     = 64'(t_r) * 64'(qb_r);
        x_nxt     = qa_r;
        state_nxt = S_EL_SHF;
      end
      S_EL_SHF: begin
        mp_nxt    = ges_pkg::sat64(p_shf);
        state_nxt = S_EL_WR;
      end
      S_EL_WR: begin
        we = 1'b1;
        wa = addr(k_r, j_r);
        wd = ges_pkg::sat64(64'(x_r) - 64'(mp_r));
        if (j_r == m_r) begin
          if (k_r == m_r - 1'b1) begin
            if (i_r == m_r - CW'(2)) begin
              state_nxt = S_BS_INIT;
            end else begin
              i_nxt     = i_r + 1'b1;
              k_nxt     = i_r + CW'(2);
              state_nxt = S_PIV_RD;
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_EL_RD;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_EL_RRD;
        end
      end
      S_BS_INIT: begin
        i_nxt     = m_r - 1'b1;
        state_nxt = S_BS_XRD;
      end
      S_BS_XRD: begin
        ra = addr(i_r, m_r);
        state_nxt = S_BS_XLD;
      end
      S_BS_XLD: begin
        x_nxt = qa_r;
        j_nxt = i_r + 1'b1;
        state_nxt = (i_r + 1'b1 == m_r) ? S_BS_DRD : S_BS_RD;
      end
      S_BS_RD: begin
        ra     = addr(i_r, j_r);
        sol_ra = SW'(j_r);
        state_nxt = S_BS_MUL;
      end
      S_BS_MUL: begin
        p_nxt     = 64'(qa_r) * 64'(sol_q_r);
        state_nxt = S_BS_SHF;
      end
      S_BS_SHF: begin
        mp_nxt    = ges_pkg::sat64(p_shf);
        state_nxt = S_BS_SUB;
      end
      S_BS_SUB: begin
        x_nxt = ges_pkg::sat64(64'(x_r) - 64'(mp_r));
        if (j_r == m_r - 1'b1) begin
          state_nxt = S_BS_DRD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_BS_RD;
        end
      end
      S_BS_DRD: begin
        ra = addr(i_r, i_r);
        state_nxt = S_BS_DIV;
      end
      S_BS_DIV: begin
        dv_start  = 1'b1;
        dv_num    = x_r;
        dv_den    = qa_r;
        state_nxt = S_BS_WT;
      end
      S_BS_WT: begin
        if (dv_done) begin
          sol_we   = 1'b1;
          sing_nxt = sing_r | dv_dz;
          if (i_r == '0) begin
            j_nxt     = '0;
            state_nxt = S_OUT_RD;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_BS_XRD;
          end
        end
      end
      S_OUT_RD: begin
        sol_ra    = SW'(j_r);
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        ov_nxt          = 1'b1;
        od_nxt.index    = ges_pkg::IDX_W'(j_r);
        od_nxt.result   = sol_q_r;
        od_nxt.singular = sing_r;
        od_nxt.last     = (j_r == m_r - 1'b1);
        state_nxt       = S_OUT_WT;
      end
      S_OUT_WT: begin
        if (!out_stall) begin
          ov_nxt = 1'b0;
          if (od_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sing_r  <= 1'b0;
      ov_r    <= 1'b0;
      cp_we_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sing_r  <= sing_nxt;
      ov_r    <= ov_nxt;
      cp_we_r <= (state_r == S_COPY);
    end
    cp_wa_r <= cnt_r;
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    cnt_r   <= cnt_nxt;
    t_r     <= t_nxt;
    x_r     <= x_nxt;
    mp_r    <= mp_nxt;
    p_r     <= p_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ===== src/gaussian_elimination_solver_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_elimination_solver_unit
// Load beats are accepted only while the sequencer is idle. A solve beat copies
// the matrix into the working copy, then runs elimination and back-substitution,
// on the order of m^3 multiply steps plus m*(m+1)/2 divisions; results then leave
// one beat at a time, each held until the receiver stops stalling.
// Reset sets order to 16 and empties the sequencer; the stores are not cleared.
// ----------------------------------------------------------------------------
module gaussian_elimination_solver_unit #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ges_pkg::ORD_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ges_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ges_pkg::out_beat_t          out_data
);

  localparam int CW = $clog2(MAX_ORDER + 2);

  logic [ges_pkg::ORD_W-1:0] order_r;
  logic [CW-1:0]             m_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ges_pkg::ORD_W'(16);
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (order_r == '0) begin
      m_act = CW'(1);
    end else if (32'(order_r) > MAX_ORDER) begin
      m_act = CW'(MAX_ORDER);
    end else begin
      m_act = CW'(order_r);
    end
  end

  ges_core #(
    .MAX_ORDER (MAX_ORDER),
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .m_act     (m_act),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the linear system solver beat by beat. The whole augmented matrix is
// loaded once, then directed and random load/solve sequences run under several
// idle and stall patterns; each solution beat is compared field by field with
// a fixed-point elimination predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DIM = 16;
  localparam int NCOL = DIM + 1;
  localparam int FRAC = 16;
  localparam int SETTLE = 40;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [ges_pkg::ORD_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  ges_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  ges_pkg::out_beat_t out_data;

  gaussian_elimination_solver_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  logic signed [31:0] matrix_mirror [DIM][NCOL];
  logic signed [31:0] work_rows [DIM][NCOL];
  logic signed [31:0] solution [DIM];
  bit zero_pivot;
  int order_reg;
  ges_pkg::out_beat_t solution_q [$];

  int idle_mode;
  int hold_seq;
  int errors;
  int beats_sent;
  int solves_sent;
  int beats_checked;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [31:0] sat_q(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat_q(p >>> FRAC);
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat_q(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] q_div(input logic signed [31:0] a,
                                               input logic signed [31:0] d);
    if (d == 0) begin
      zero_pivot = 1'b1;
      return 32'sd0;
    end
    return sat_q((longint'(a) <<< FRAC) / longint'(d));
  endfunction

  function automatic longint q_mag(input logic signed [31:0] v);
    longint w;
    w = longint'(v);
    return (w < 0) ? -w : w;
  endfunction

  task automatic solve_system(input int m);
    logic signed [31:0] t;
    logic signed [31:0] term;
    logic signed [31:0] acc;
    ges_pkg::out_beat_t r;
    work_rows = matrix_mirror;
    zero_pivot = 1'b0;
    for (int i = 0; i + 1 < m; i++) begin
      for (int k = i + 1; k < m; k++) begin
        if (q_mag(work_rows[i][i]) < q_mag(work_rows[k][i])) begin
          for (int j = 0; j < NCOL; j++) begin
            t = work_rows[i][j];
            work_rows[i][j] = work_rows[k][j];
            work_rows[k][j] = t;
          end
        end
      end
      for (int k = i + 1; k < m; k++) begin
        term = q_div(work_rows[k][i], work_rows[i][i]);
        for (int j = i; j <= m; j++)
          work_rows[k][j] = q_sub(work_rows[k][j], q_mul(term, work_rows[i][j]));
      end
    end
    for (int i = m - 1; i >= 0; i--) begin
      acc = work_rows[i][m];
      for (int j = i + 1; j < m; j++)
        acc = q_sub(acc, q_mul(work_rows[i][j], solution[j]));
      solution[i] = q_div(acc, work_rows[i][i]);
    end
    for (int i = 0; i < m; i++) begin
      r.index = ges_pkg::IDX_W'(i);
      r.result = solution[i];
      r.singular = zero_pivot;
      r.last = (i == m - 1);
      solution_q.push_back(r);
    end
  endtask

  task automatic apply_beat(input ges_pkg::in_beat_t b);
    int m;
    if (b.row < DIM && b.col <= DIM) matrix_mirror[b.row][b.col] = b.value;
    if (b.solve_req) begin
      m = (order_reg == 0) ? 1 : (order_reg > DIM) ? DIM : order_reg;
      solve_system(m);
    end
  endtask

  task automatic send_beat(input ges_pkg::in_beat_t b);
    bit stalled;
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 56 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    beats_sent++;
    if (b.solve_req) solves_sent++;
    apply_beat(b);
  endtask

  task automatic send_elem(input int r, input int c, input logic signed [31:0] v,
                           input bit go);
    ges_pkg::in_beat_t b;
    b.row = ges_pkg::ROW_W'(r);
    b.col = ges_pkg::COL_W'(c);
    b.value = v;
    b.solve_req = go;
    send_beat(b);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sd0;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3, 4: return $urandom;
      default: return 32'(signed'($urandom_range(32'h7FFFF) - 32'h3FFFF));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(input int v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ges_pkg::ORD_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_reg = v;
  endtask

  // receiver: random stall per mode, plus a long hold-off on request
  always @(posedge clk) begin
    static int seen_seq = 0;
    static int hold_left = 0;
    int stall_pct;
    stall_pct = (idle_mode == IDLE_RECV) ? 56 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk) begin
    ges_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (solution_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, out_data);
      end else begin
        want = solution_q.pop_front();
        if (out_data.index !== want.index || out_data.result !== want.result ||
            out_data.singular !== want.singular || out_data.last !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
        end
      end
    end
  end

  task automatic test_full_load();
    idle_mode = IDLE_NONE;
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < NCOL; c++)
        send_elem(r, c, pick_value(), 1'b0);
    drain();
  endtask

  task automatic test_directed();
    ges_pkg::in_beat_t b;
    send_elem(DIM - 1, DIM, 32'sh7FFF_FFFF, 1'b1);
    drain();
    write_order(0);
    send_elem(0, 0, 32'sd0, 1'b1);
    send_elem(0, 1, 32'sh8000_0000, 1'b0);
    send_elem(0, 0, 32'sh8000_0000, 1'b1);
    send_elem(0, 0, 32'sh0001_0000, 1'b0);
    send_elem(0, 20, 32'sh1234_5678, 1'b1);
    b.row = '1;
    b.col = '1;
    b.value = 32'sh7FFF_FFFF;
    b.solve_req = 1'b1;
    send_beat(b);
    drain();
    write_order(2);
    send_elem(0, 0, 32'sd0, 1'b0);
    send_elem(1, 0, 32'sh0002_0000, 1'b0);
    send_elem(0, 1, 32'sh0001_0000, 1'b0);
    send_elem(1, 1, 32'sh0001_0000, 1'b0);
    send_elem(0, 2, 32'sh0003_0000, 1'b0);
    send_elem(1, 2, 32'sh0004_0000, 1'b1);
    send_elem(1, 0, 32'sd0, 1'b0);
    send_elem(1, 1, 32'sd0, 1'b1);
    drain();
    write_order(31);
    send_elem(5, 5, 32'sh0000_8000, 1'b1);
    drain();
  endtask

  task automatic test_random_phase(input int mode, input int sequences);
    int m;
    idle_mode = mode;
    for (int s = 0; s < sequences; s++) begin
      m = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
      write_order(m);
      repeat ($urandom_range(m, 1)) begin
        if ($urandom_range(9) == 0)
          send_elem($urandom_range(15), $urandom_range(31, 17), $urandom, 1'b0);
        else
          send_elem($urandom_range(m - 1), $urandom_range(m), pick_value(), 1'b0);
      end
      send_elem($urandom_range(m - 1), $urandom_range(m), pick_value(), 1'b1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    write_order(3);
    hold_seq++;
    repeat (6) send_elem($urandom_range(2), $urandom_range(3), pick_value(), 1'b1);
    drain();
  endtask

  task automatic test_single_unknown();
    idle_mode = IDLE_NONE;
    write_order(1);
    send_elem(0, 1, pick_value(), 1'b1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    idle_mode = IDLE_NONE;
    hold_seq = 0;
    errors = 0;
    beats_sent = 0;
    solves_sent = 0;
    beats_checked = 0;
    order_reg = DIM;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_load();
    test_directed();
    test_random_phase(IDLE_NONE, 3);
    test_random_phase(IDLE_SEND, 3);
    test_random_phase(IDLE_RECV, 3);
    test_random_phase(IDLE_BOTH, 3);
    test_backpressure();
    test_single_unknown();

    $display("Run covered %0d input beats, %0d solves, %0d solution beats checked",
             beats_sent, solves_sent, beats_checked);
    $display("Orders from zero to past the maximum, idle and stall phases, long hold-off");
    if (errors == 0 && solution_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
